// ----- hdl/pmmu_pkg.sv -----
// ============================================================================
// pmmu_pkg
// Shared types and constants for the paged MMU with not-recently-used
// frame replacement: default sizes, result status codes, request kinds.
// ============================================================================
package pmmu_pkg;

    // Default geometry
    localparam int PROCESSES_DEF         = 4;
    localparam int PAGES_PER_PROCESS_DEF = 16;
    localparam int FRAMES_DEF            = 4;
    localparam int PAGE_BYTES_DEF        = 64;   // power of two

    // Fixed limits
    localparam logic [15:0] MAX_VADDR     = 16'd1023;
    localparam logic [15:0] FAULT_MAX     = 16'hFFFF;
    localparam logic [2:0]  AGE_MAX       = 3'd7;
    localparam logic [2:0]  AGE_LIMIT_RST = 3'd5;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_ACCESS  = 2'd0,
        KIND_TICK    = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_UNUSED  = 2'd3
    } t_kind;

    // Result status codes
    typedef enum logic [2:0] {
        ST_DONE       = 3'd0,
        ST_HIT        = 3'd1,
        ST_MISS_FREE  = 3'd2,
        ST_MISS_EVICT = 3'd3,
        ST_RANGE_ERR  = 3'd4
    } t_status;

endpackage

// ----- hdl/paged_mmu_nru_replace_core.sv -----
// ============================================================================
// paged_mmu_nru_replace_core
// Per-process virtual-to-physical translation with a frame-indexed table.
// One shared scan over the frames finds a hit, the lowest free frame and
// the NRU victim (lowest {ref, mod, process, page} key); ticks and
// releases walk the same frame table one entry per cycle.
// ============================================================================
// Items are taken one at a time: the input stalls until the current item has
//   been handed to the output register. The frame scan visits one frame per cycle.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low): all frames free, fault counters zero,
//   age limit 5, both channels empty.
module paged_mmu_nru_replace_core #(
    parameter int PROCESSES         = pmmu_pkg::PROCESSES_DEF,
    parameter int PAGES_PER_PROCESS = pmmu_pkg::PAGES_PER_PROCESS_DEF,
    parameter int FRAMES            = pmmu_pkg::FRAMES_DEF,
    parameter int PAGE_BYTES        = pmmu_pkg::PAGE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_wr_data,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [1:0]  i_process_id,
    input  logic [15:0] i_virt_addr,
    input  logic        i_is_write,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_phys_addr,
    output logic        o_evicted,
    output logic [1:0]  o_evict_process,
    output logic [3:0]  o_evict_page,
    output logic [15:0] o_fault_total
);

    localparam int PID_W = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int PG_W  = $clog2(PAGES_PER_PROCESS);
    localparam int FW    = $clog2(FRAMES);
    localparam int OFF_W = $clog2(PAGE_BYTES);
    localparam int KEY_W = 2 + PID_W + PG_W;

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_UPD  = 6'b000100,
        S_TICK = 6'b001000,
        S_REL  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Frame table: one entry per physical frame
    logic [FRAMES-1:0] r_fr_valid;
    logic              r_fr_ref  [FRAMES];
    logic              r_fr_mod  [FRAMES];
    logic [2:0]        r_fr_age  [FRAMES];
    logic [PID_W-1:0]  r_fr_pid  [FRAMES];
    logic [PG_W-1:0]   r_fr_page [FRAMES];

    logic [15:0]       r_fault [PROCESSES];
    logic [2:0]        r_age_limit;

    // Request context
    logic [PID_W-1:0]  r_pid,  n_pid;
    logic [PG_W-1:0]   r_page, n_page;
    logic [OFF_W-1:0]  r_off,  n_off;
    logic              r_wr,   n_wr;

    // Scan bookkeeping
    logic [FW-1:0]     r_idx, n_idx;
    logic              r_hit, n_hit;
    logic [FW-1:0]     r_hit_idx, n_hit_idx;
    logic              r_free_found, n_free_found;
    logic [FW-1:0]     r_free_idx, n_free_idx;
    logic              r_best_found, n_best_found;
    logic [KEY_W-1:0]  r_best_key, n_best_key;
    logic [FW-1:0]     r_best_idx, n_best_idx;

    // Staged result
    pmmu_pkg::t_status r_res_status, n_res_status;
    logic [7:0]        r_res_phys,   n_res_phys;
    logic              r_res_ev,     n_res_ev;
    logic [1:0]        r_res_evp,    n_res_evp;
    logic [3:0]        r_res_evg,    n_res_evg;
    logic [15:0]       r_res_ftot,   n_res_ftot;

    // Output register
    logic              r_out_valid;
    pmmu_pkg::t_status r_out_status;
    logic [7:0]        r_out_phys;
    logic              r_out_ev;
    logic [1:0]        r_out_evp;
    logic [3:0]        r_out_evg;
    logic [15:0]       r_out_ftot;

    // Frame table write port
    logic              w_fr_we;
    logic [FW-1:0]     w_fr_widx;
    logic              w_fr_wvalid, w_fr_wref, w_fr_wmod;
    logic [2:0]        w_fr_wage;
    logic [PID_W-1:0]  w_fr_wpid;
    logic [PG_W-1:0]   w_fr_wpage;

    // Fault counter write port
    logic              w_fc_we;
    logic [PID_W-1:0]  w_fc_widx;
    logic [15:0]       w_fc_wdata;

    logic              w_out_load;

    // Current scan entry
    logic              e_valid, e_ref, e_mod;
    logic [2:0]        e_age;
    logic [PID_W-1:0]  e_pid;
    logic [PG_W-1:0]   e_page;
    logic [KEY_W-1:0]  w_key;
    logic              w_last;

    // Request decode
    logic [31:0]       w_pid32;
    logic [PID_W-1:0]  w_pid_idx;
    logic              w_pid_ok;
    logic [15:0]       w_page_full;
    logic              w_range_err;

    // Update helpers
    logic [FW-1:0]     w_sel_frame;
    logic [31:0]       w_phys32;
    logic [31:0]       w_evp32;
    logic [31:0]       w_evg32;
    logic [2:0]        w_lim;
    logic [2:0]        w_age_inc;

    assign e_valid = r_fr_valid[r_idx];
    assign e_ref   = r_fr_ref[r_idx];
    assign e_mod   = r_fr_mod[r_idx];
    assign e_age   = r_fr_age[r_idx];
    assign e_pid   = r_fr_pid[r_idx];
    assign e_page  = r_fr_page[r_idx];
    assign w_key   = {e_ref, e_mod, e_pid, e_page};
    assign w_last  = (r_idx == FW'(FRAMES - 1));

    // Page size is a power of two: page and offset are a bit split
    assign w_pid32     = 32'(i_process_id);
    assign w_pid_idx   = w_pid32[PID_W-1:0];
    assign w_pid_ok    = (w_pid32 < 32'(PROCESSES));
    assign w_page_full = i_virt_addr >> OFF_W;
    assign w_range_err = (i_virt_addr > pmmu_pkg::MAX_VADDR)
                      || (32'(w_page_full) >= 32'(PAGES_PER_PROCESS))
                      || !w_pid_ok;

    // Frame chosen by the update step: hit, lowest free, else NRU victim
    assign w_sel_frame = r_hit ? r_hit_idx : (r_free_found ? r_free_idx : r_best_idx);
    assign w_phys32    = (32'(w_sel_frame) << OFF_W) | 32'(r_off);
    assign w_evp32     = 32'(r_best_key[PG_W +: PID_W]);
    assign w_evg32     = 32'(r_best_key[PG_W-1:0]);

    // Aging
    assign w_lim     = (r_age_limit == 3'd0) ? 3'd1 : r_age_limit;
    assign w_age_inc = (e_age < pmmu_pkg::AGE_MAX) ? e_age + 3'd1 : e_age;

    assign o_in_stall = (r_state != S_IDLE);

    // Sequencer and datapath control
    always_comb begin
        n_state      = r_state;
        n_pid        = r_pid;
        n_page       = r_page;
        n_off        = r_off;
        n_wr         = r_wr;
        n_idx        = r_idx;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_best_found = r_best_found;
        n_best_key   = r_best_key;
        n_best_idx   = r_best_idx;
        n_res_status = r_res_status;
        n_res_phys   = r_res_phys;
        n_res_ev     = r_res_ev;
        n_res_evp    = r_res_evp;
        n_res_evg    = r_res_evg;
        n_res_ftot   = r_res_ftot;

        w_fr_we      = 1'b0;
        w_fr_widx    = r_idx;
        w_fr_wvalid  = e_valid;
        w_fr_wref    = e_ref;
        w_fr_wmod    = e_mod;
        w_fr_wage    = e_age;
        w_fr_wpid    = e_pid;
        w_fr_wpage   = e_page;

        w_fc_we      = 1'b0;
        w_fc_widx    = r_pid;
        w_fc_wdata   = r_fault[r_pid];

        w_out_load   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_pid        = w_pid_idx;
                    n_page       = w_page_full[PG_W-1:0];
                    n_off        = i_virt_addr[OFF_W-1:0];
                    n_wr         = i_is_write;
                    n_idx        = '0;
                    n_hit        = 1'b0;
                    n_free_found = 1'b0;
                    n_best_found = 1'b0;
                    n_res_status = pmmu_pkg::ST_DONE;
                    n_res_phys   = '0;
                    n_res_ev     = 1'b0;
                    n_res_evp    = '0;
                    n_res_evg    = '0;
                    n_res_ftot   = '0;
                    case (pmmu_pkg::t_kind'(i_kind))
                        pmmu_pkg::KIND_ACCESS: begin
                            if (w_range_err) begin
                                n_res_status = pmmu_pkg::ST_RANGE_ERR;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        pmmu_pkg::KIND_TICK: begin
                            n_state = S_TICK;
                        end
                        pmmu_pkg::KIND_RELEASE: begin
                            if (w_pid_ok) begin
                                // report and clear the fault count, then free pages
                                n_res_ftot = r_fault[w_pid_idx];
                                w_fc_we    = 1'b1;
                                w_fc_widx  = w_pid_idx;
                                w_fc_wdata = '0;
                                n_state    = S_REL;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // One frame per cycle: hit match, first free, minimum NRU key
            S_SCAN: begin
                if (e_valid && e_pid == r_pid && e_page == r_page) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_idx;
                end
                if (!e_valid && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_idx;
                end
                if (e_valid && (!r_best_found || w_key < r_best_key)) begin
                    n_best_found = 1'b1;
                    n_best_key   = w_key;
                    n_best_idx   = r_idx;
                end
                if (w_last) begin
                    n_state = S_UPD;
                end else begin
                    n_idx = r_idx + FW'(1);
                end
            end

            // Install or refresh the page in the chosen frame
            S_UPD: begin
                w_fr_we     = 1'b1;
                w_fr_widx   = w_sel_frame;
                w_fr_wvalid = 1'b1;
                w_fr_wref   = 1'b1;
                w_fr_wmod   = r_wr;
                w_fr_wage   = '0;
                w_fr_wpid   = r_pid;
                w_fr_wpage  = r_page;
                n_res_phys  = w_phys32[7:0];
                if (r_hit) begin
                    n_res_status = pmmu_pkg::ST_HIT;
                end else begin
                    if (r_free_found) begin
                        n_res_status = pmmu_pkg::ST_MISS_FREE;
                    end else begin
                        n_res_status = pmmu_pkg::ST_MISS_EVICT;
                        n_res_ev     = 1'b1;
                        n_res_evp    = w_evp32[1:0];
                        n_res_evg    = w_evg32[3:0];
                    end
                    // saturating fault count
                    if (r_fault[r_pid] != pmmu_pkg::FAULT_MAX) begin
                        w_fc_we    = 1'b1;
                        w_fc_wdata = r_fault[r_pid] + 16'd1;
                    end
                end
                n_state = S_DONE;
            end

            // Age referenced resident pages, drop the mark at the limit
            S_TICK: begin
                if (e_valid && e_ref) begin
                    w_fr_we = 1'b1;
                    if (w_age_inc >= w_lim) begin
                        w_fr_wref = 1'b0;
                        w_fr_wage = '0;
                    end else begin
                        w_fr_wage = w_age_inc;
                    end
                end
                if (w_last) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + FW'(1);
                end
            end

            // Free every frame owned by the released process
            S_REL: begin
                if (e_valid && e_pid == r_pid) begin
                    w_fr_we     = 1'b1;
                    w_fr_wvalid = 1'b0;
                end
                if (w_last) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + FW'(1);
                end
            end

            // Hand the result over once the output register is free
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_age_limit <= pmmu_pkg::AGE_LIMIT_RST;
            r_fr_valid  <= '0;
            r_out_valid <= 1'b0;
            for (int p = 0; p < PROCESSES; p++) begin
                r_fault[p] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_age_limit <= i_cfg_wr_data;
            end
            if (w_fr_we) begin
                r_fr_valid[w_fr_widx] <= w_fr_wvalid;
            end
            if (w_fc_we) begin
                r_fault[w_fc_widx] <= w_fc_wdata;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Frame table payload
    always_ff @(posedge i_clk) begin
        if (w_fr_we) begin
            r_fr_ref[w_fr_widx]  <= w_fr_wref;
            r_fr_mod[w_fr_widx]  <= w_fr_wmod;
            r_fr_age[w_fr_widx]  <= w_fr_wage;
            r_fr_pid[w_fr_widx]  <= w_fr_wpid;
            r_fr_page[w_fr_widx] <= w_fr_wpage;
        end
    end

    // Context, scan and result payload
    always_ff @(posedge i_clk) begin
        r_pid        <= n_pid;
        r_page       <= n_page;
        r_off        <= n_off;
        r_wr         <= n_wr;
        r_idx        <= n_idx;
        r_hit        <= n_hit;
        r_hit_idx    <= n_hit_idx;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_best_found <= n_best_found;
        r_best_key   <= n_best_key;
        r_best_idx   <= n_best_idx;
        r_res_status <= n_res_status;
        r_res_phys   <= n_res_phys;
        r_res_ev     <= n_res_ev;
        r_res_evp    <= n_res_evp;
        r_res_evg    <= n_res_evg;
        r_res_ftot   <= n_res_ftot;
        if (w_out_load) begin
            r_out_status <= r_res_status;
            r_out_phys   <= r_res_phys;
            r_out_ev     <= r_res_ev;
            r_out_evp    <= r_res_evp;
            r_out_evg    <= r_res_evg;
            r_out_ftot   <= r_res_ftot;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_phys_addr     = r_out_phys;
    assign o_evicted       = r_out_ev;
    assign o_evict_process = r_out_evp;
    assign o_evict_page    = r_out_evg;
    assign o_fault_total   = r_out_ftot;

    // Eviction only when no frame was free
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && !r_hit && !r_free_found) |-> (&r_fr_valid))
        else $error("eviction chosen while a frame was free");

    // Resident frames only go away on a release
    a_no_frame_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_REL) |=> ($countones(r_fr_valid) >= $past($countones(r_fr_valid))))
        else $error("frame freed outside a release");

    // Evicted flag goes with the eviction status
    a_evict_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_evicted == (o_status == pmmu_pkg::ST_MISS_EVICT)))
        else $error("evicted flag disagrees with status");

    // A found hit always drives a hit status
    a_hit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && r_hit) |=> (r_res_status == pmmu_pkg::ST_HIT))
        else $error("hit not reported as hit");

endmodule
